// ===== src/chr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package chr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 20;
  localparam int CHAN_W   = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  // working width of the cubic coefficients and the horner partial results
  localparam int COEF_W   = 24;

  // register select, taken from paddr[2]
  localparam logic REG_STEP_RATIO    = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       final_frame;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       run_end;
    logic                       stream_end;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/cubic_hermite_resampler_unit.sv =====
// catmull-rom cubic resampler, one shared multiplier under a small sequencer
// a frame is taken in idle and checked; each result runs the horner steps for left, then
// right in stereo, and waits to emit while the output register is held by a low out_ready
// each result is three horner steps per channel, each a multiply then an accumulate
// synchronous active-low reset clears the sequencer and valid flag and loads the config
// registers with their reset values; sample history and datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module cubic_hermite_resampler_unit #(
  parameter int MAX_CHANNELS  = 2,
  parameter int FRACTION_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  chr_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output chr_pkg::out_item_t               out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [chr_pkg::ADDR_W-1:0]       paddr,
  input  wire  [chr_pkg::DATA_W-1:0]       pwdata,
  output logic [chr_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int SW     = chr_pkg::SAMPLE_W;
  localparam int CW     = chr_pkg::COEF_W;
  localparam int POS_W  = chr_pkg::STEP_W + 1;
  localparam int MUL_W  = CW + FRACTION_BITS + 1;
  localparam int ACC_W  = MUL_W + 1;

  localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRACTION_BITS;
  localparam logic [POS_W-1:0] TWO_POS  = POS_W'(2) << FRACTION_BITS;
  localparam logic [chr_pkg::STEP_W-1:0] MIN_STEP =
    chr_pkg::STEP_W'(1) << (FRACTION_BITS - 4);
  localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);
  localparam logic [1:0] K_LAST = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  state_t                          state_r;
  logic signed [SW-1:0]            hist_r [MAX_CHANNELS][4];
  logic [1:0]                      frames_r;
  logic [POS_W-1:0]                pos_r;
  logic                            fin_r;
  logic [1:0]                      pass_r;
  logic                            ch_r;
  logic [1:0]                      k_r;
  logic signed [CW-1:0]            u_r;
  logic signed [MUL_W-1:0]         prod_r;
  logic signed [SW-1:0]            left_res_r;
  logic signed [SW-1:0]            right_res_r;
  logic                            out_valid_r;
  chr_pkg::out_item_t              out_data_r;
  logic [chr_pkg::STEP_W-1:0]      step_r;
  logic [chr_pkg::CHAN_W-1:0]      chan_r;

  logic                            mono;
  logic [chr_pkg::STEP_W-1:0]      step_eff;
  logic signed [CW-1:0]            e0, e1, e2, e3;
  logic signed [CW-1:0]            coef_a, coef_b, coef_c, addend, mul_opa;
  logic signed [FRACTION_BITS:0]   mul_opf;
  logic signed [ACC_W-1:0]         acc_sum, rnd;
  logic signed [SW-1:0]            sat_val;
  logic [POS_W-1:0]                pos_next, pos_limit;
  logic                            more;
  logic                            cfg_wr;
  logic                            emit_go;

  assign mono     = (MAX_CHANNELS < 2) || (chan_r < 2'd2);
  assign step_eff = (step_r < MIN_STEP) ? MIN_STEP : step_r;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    if (paddr[2] == chr_pkg::REG_CHANNEL_COUNT) begin
      prdata = chr_pkg::DATA_W'(chan_r);
    end else begin
      prdata = chr_pkg::DATA_W'(step_r);
    end
  end

  // the four points of the channel being worked on
  always_comb begin
    if (ch_r && (MAX_CHANNELS > 1)) begin
      e0 = CW'(hist_r[MAX_CHANNELS-1][0]);
      e1 = CW'(hist_r[MAX_CHANNELS-1][1]);
      e2 = CW'(hist_r[MAX_CHANNELS-1][2]);
      e3 = CW'(hist_r[MAX_CHANNELS-1][3]);
    end else begin
      e0 = CW'(hist_r[0][0]);
      e1 = CW'(hist_r[0][1]);
      e2 = CW'(hist_r[0][2]);
      e3 = CW'(hist_r[0][3]);
    end
  end

  // twice the true coefficients
  assign coef_a = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
  assign coef_b = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign coef_c = e2 - e0;

  assign mul_opa = (k_r == 2'd0) ? coef_a : u_r;
  assign mul_opf = signed'({1'b0, pos_r[FRACTION_BITS-1:0]});

  // rounding half is folded into the addend: 2*p1 is even, so +1 lands at the final half
  always_comb begin
    unique case (k_r)
      2'd0:    addend = coef_b;
      2'd1:    addend = coef_c;
      default: addend = (e1 <<< 1) + CW'(1);
    endcase
  end

  always_comb begin
    if (k_r == K_LAST) begin
      acc_sum = ACC_W'(prod_r) + (ACC_W'(addend) <<< FRACTION_BITS);
      rnd     = acc_sum >>> (FRACTION_BITS + 1);
    end else begin
      acc_sum = ACC_W'(prod_r) + ((ACC_W'(addend) <<< FRACTION_BITS) | HALF_LSB);
      rnd     = acc_sum >>> FRACTION_BITS;
    end
  end

  always_comb begin
    if (rnd > SAT_HI) begin
      sat_val = SW'(SAT_HI);
    end else if (rnd < SAT_LO) begin
      sat_val = SW'(SAT_LO);
    end else begin
      sat_val = SW'(rnd);
    end
  end

  // another result is due in this frame if the next position falls before the
  // end of the remaining flush passes
  assign pos_next  = pos_r + POS_W'(step_eff);
  assign pos_limit = (POS_W'(pass_r) + POS_W'(1)) << FRACTION_BITS;
  assign more      = (pos_next < pos_limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frames_r    <= 2'd0;
      out_valid_r <= 1'b0;
      step_r      <= chr_pkg::STEP_RESET;
      chan_r      <= chr_pkg::CHAN_RESET;
      pass_r      <= 2'd0;
      ch_r        <= 1'b0;
      k_r         <= 2'd0;
      fin_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == chr_pkg::REG_CHANNEL_COUNT) begin
          chan_r <= pwdata[chr_pkg::CHAN_W-1:0];
        end else begin
          step_r <= pwdata[chr_pkg::STEP_W-1:0];
        end
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
              if (frames_r == 2'd0) begin
                for (int j = 0; j < 4; j++) begin
                  hist_r[c][j] <= (c == 0) ? in_data.left_sample : in_data.right_sample;
                end
              end else begin
                for (int j = 0; j < 3; j++) begin
                  hist_r[c][j] <= hist_r[c][j+1];
                end
                hist_r[c][3] <= (c == 0) ? in_data.left_sample : in_data.right_sample;
              end
            end
            if (frames_r == 2'd0) begin
              pos_r <= TWO_POS;
            end else begin
              pos_r <= pos_r - ONE_POS;
            end
            if (in_data.final_frame) begin
              frames_r <= 2'd0;
            end else if (frames_r != 2'd3) begin
              frames_r <= frames_r + 2'd1;
            end
            fin_r   <= in_data.final_frame;
            pass_r  <= in_data.final_frame ? 2'd2 : 2'd0;
            state_r <= S_CHECK;
          end
        end

        S_CHECK: begin
          priority if (pos_r < ONE_POS) begin
            ch_r    <= 1'b0;
            k_r     <= 2'd0;
            state_r <= S_MUL;
          end else if (pass_r != 2'd0) begin
            // flush: repeat the newest frame past the end
            for (int c = 0; c < MAX_CHANNELS; c++) begin
              for (int j = 0; j < 3; j++) begin
                hist_r[c][j] <= hist_r[c][j+1];
              end
            end
            pos_r  <= pos_r - ONE_POS;
            pass_r <= pass_r - 2'd1;
          end else begin
            state_r <= S_IDLE;
          end
        end

        S_MUL: begin
          prod_r  <= mul_opa * mul_opf;
          state_r <= S_ACC;
        end

        S_ACC: begin
          if (k_r != K_LAST) begin
            u_r     <= CW'(rnd);
            k_r     <= k_r + 2'd1;
            state_r <= S_MUL;
          end else begin
            if (ch_r) begin
              right_res_r <= sat_val;
            end else begin
              left_res_r <= sat_val;
            end
            if (!ch_r && !mono) begin
              ch_r    <= 1'b1;
              k_r     <= 2'd0;
              state_r <= S_MUL;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (emit_go) begin
            out_data_r.left_out   <= left_res_r;
            out_data_r.right_out  <= mono ? '0 : right_res_r;
            out_data_r.run_end    <= !more;
            out_data_r.stream_end <= fin_r && !more;
            pos_r                 <= pos_next;
            state_r               <= more ? S_CHECK : S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_stream_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_end)
    else $error("stream end without run end");

  a_mono_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mono |-> out_data.right_out == '0)
    else $error("right channel not zero in mono");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted request");

  a_position_in_interval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL && k_r == 2'd0 |-> pos_r < ONE_POS)
    else $error("interpolating outside the current interval");

endmodule

`default_nettype wire
